[rtl/rrba_pkg.sv]
// ----------------------------------------------------------------------------
// rrba_pkg
// Shared types and constants of the region bump allocator.
// ----------------------------------------------------------------------------
package rrba_pkg;

	localparam int MAX_REGIONS_DEF  = 16;
	localparam int PAGE_BYTES_DEF   = 4096;
	localparam int ALIGN_UNIT_DEF   = 8;
	localparam int HEADER_BYTES_DEF = 32;

	localparam logic [6:0]  PAGES_RESET = 7'd16;
	localparam logic [31:0] BASE_RESET  = 32'h00a0_0000;
	localparam logic [23:0] REFS_MAX    = 24'hff_ffff;

	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-1:0] REG_PAGES = 3'd0;
	localparam logic [ADDR_W-1:0] REG_BASE  = 3'd4;

	localparam logic [2:0] ST_ALLOC    = 3'd0;
	localparam logic [2:0] ST_FREED    = 3'd1;
	localparam logic [2:0] ST_RELEASED = 3'd2;
	localparam logic [2:0] ST_TOO_BIG  = 3'd3;
	localparam logic [2:0] ST_NO_SLOT  = 3'd4;
	localparam logic [2:0] ST_NOT_IN   = 3'd5;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load;      // latch the input word, clear scan state
		logic scan;      // examine slot at the scan index
		logic commit;    // apply the chosen update and build the result
	} rrba_cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic scan_last; // scan index is at the last slot
	} rrba_sts_t;

endpackage

[rtl/rrba_if.sv]
// ----------------------------------------------------------------------------
// rrba_in_if / rrba_out_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface rrba_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [23:0] request_bytes;
	logic [31:0] free_address;
	modport source (output valid, mode, request_bytes, free_address, input ready);
	modport sink (input valid, mode, request_bytes, free_address, output ready);
endinterface

interface rrba_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] block_address;
	logic [2:0]  status;
	logic        opened_region;
	modport source (output valid, block_address, status, opened_region, input ready);
	modport sink (input valid, block_address, status, opened_region, output ready);
endinterface

[rtl/rrba_ctrl.sv]
// ----------------------------------------------------------------------------
// rrba_ctrl
// Sequencer: load, scan all slots, commit, hold result until taken.
// ----------------------------------------------------------------------------
module rrba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output rrba_pkg::rrba_cmd_t cmd,
	input  rrba_pkg::rrba_sts_t sts
);
	import rrba_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;
	localparam logic [1:0] S_OUT = 2'd3;

	logic [1:0] state_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.scan = (state_q == S_SCAN);
		cmd.commit = (state_q == S_COMMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_last) state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_commit_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $past(cmd.scan)) else $error("commit without scan");
	a_out_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.commit)) else $error("result without commit");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !out_valid) else $error("load while result pending");
endmodule

[rtl/rrba_dp.sv]
// ----------------------------------------------------------------------------
// rrba_dp
// Slot table, serial slot scan and commit arithmetic.
// ----------------------------------------------------------------------------
module rrba_dp #(
	parameter int MAX_REGIONS  = rrba_pkg::MAX_REGIONS_DEF,
	parameter int PAGE_BYTES   = rrba_pkg::PAGE_BYTES_DEF,
	parameter int ALIGN_UNIT   = rrba_pkg::ALIGN_UNIT_DEF,
	parameter int HEADER_BYTES = rrba_pkg::HEADER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rrba_pkg::rrba_cmd_t cmd,
	output rrba_pkg::rrba_sts_t sts,
	input  logic [6:0]          region_pages,
	input  logic [31:0]         arena_base,
	input  logic                in_mode,
	input  logic [23:0]         in_request_bytes,
	input  logic [31:0]         in_free_address,
	output logic [31:0]         block_address,
	output logic [2:0]          status,
	output logic                opened_region
);
	import rrba_pkg::*;

	localparam int SW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int AL_W = (ALIGN_UNIT > 1) ? $clog2(ALIGN_UNIT) : 1;
	// A 24-bit request rounded up to the alignment unit needs one more bit.
	localparam int NW = 25;
	localparam int OW = 32;
	localparam logic [OW-1:0] HDR_ROUND =
		OW'(((HEADER_BYTES + ALIGN_UNIT - 1) / ALIGN_UNIT) * ALIGN_UNIT);
	localparam logic [SW:0] LAST = (SW+1)'(MAX_REGIONS - 1);

	// Slot table: per-slot registers; live bits and stamps are read through the scan index.
	logic [MAX_REGIONS-1:0] live_q;
	logic [23:0] refs_q   [MAX_REGIONS];
	logic [OW-1:0] woff_q [MAX_REGIONS];
	logic [31:0] stamp_q  [MAX_REGIONS];
	logic [31:0] open_cnt_q;

	logic        mode_q;
	logic [NW-1:0] need_q;
	logic [31:0] faddr_q;
	logic [SW:0] idx_q;
	logic [31:0] start_q;         // start of slot idx_q
	logic        newest_ok_q;
	logic [SW-1:0] newest_q;
	logic [31:0] newest_age_q;
	logic [31:0] newest_start_q;
	logic [SW-1:0] free_slot_q;   // lowest free slot
	logic        has_free_q;
	logic        hit_q;
	logic [SW-1:0] hit_slot_q;

	logic [6:0]  pages_c;
	logic [31:0] rbytes;
	logic [SW-1:0] si;
	logic [31:0] age;
	logic [31:0] off;
	logic [NW-1:0] rounded;
	logic [OW:0] end_sum;
	logic        room;
	logic        too_big;

	always_comb begin
		pages_c = region_pages;
		if (pages_c == 7'd0) pages_c = 7'd1;
		if (pages_c > 7'd64) pages_c = 7'd64;
	end
	assign rbytes = 32'(pages_c) * 32'(PAGE_BYTES);
	assign si = idx_q[SW-1:0];
	assign age = open_cnt_q - stamp_q[si];
	assign off = faddr_q - start_q;
	assign rounded = ((NW'(in_request_bytes) + NW'(ALIGN_UNIT - 1)) >> AL_W) << AL_W;
	assign sts.scan_last = (idx_q == LAST);
	assign end_sum = {1'b0, woff_q[newest_q]} + (OW+1)'(need_q);
	assign room = end_sum <= (OW+1)'(rbytes);
	assign too_big = 32'(need_q) > (rbytes >> 6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			open_cnt_q <= '0;
		end else if (cmd.commit) begin
			if (mode_q) begin
				if (hit_q) begin
					if (refs_q[hit_slot_q] <= 24'd1) live_q[hit_slot_q] <= 1'b0;
				end
			end else if (!too_big && !(newest_ok_q && room) && has_free_q) begin
				live_q[free_slot_q] <= 1'b1;
				open_cnt_q <= open_cnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			need_q <= (ALIGN_UNIT > 1) ? rounded : NW'(in_request_bytes);
			faddr_q <= in_free_address;
			idx_q <= '0;
			start_q <= arena_base;
			newest_ok_q <= 1'b0;
			has_free_q <= 1'b0;
			hit_q <= 1'b0;
		end else if (cmd.scan) begin
			if (!sts.scan_last) idx_q <= idx_q + (SW+1)'(1);
			start_q <= start_q + rbytes;
			if (live_q[si]) begin
				if (!newest_ok_q || age < newest_age_q) begin
					newest_ok_q <= 1'b1;
					newest_q <= si;
					newest_age_q <= age;
					newest_start_q <= start_q;
				end
				if (!hit_q && off != 32'd0 && off < rbytes) begin
					hit_q <= 1'b1;
					hit_slot_q <= si;
				end
			end else if (!has_free_q) begin
				has_free_q <= 1'b1;
				free_slot_q <= si;
			end
		end else if (cmd.commit) begin
			block_address <= '0;
			opened_region <= 1'b0;
			if (mode_q) begin
				if (!hit_q) begin
					status <= ST_NOT_IN;
				end else begin
					if (refs_q[hit_slot_q] > 24'd0)
						refs_q[hit_slot_q] <= refs_q[hit_slot_q] - 24'd1;
					status <= (refs_q[hit_slot_q] <= 24'd1) ? ST_RELEASED : ST_FREED;
				end
			end else if (too_big) begin
				status <= ST_TOO_BIG;
			end else if (newest_ok_q && room) begin
				status <= ST_ALLOC;
				block_address <= newest_start_q + woff_q[newest_q];
				if (refs_q[newest_q] != REFS_MAX) refs_q[newest_q] <= refs_q[newest_q] + 24'd1;
				woff_q[newest_q] <= woff_q[newest_q] + OW'(need_q);
			end else if (!has_free_q) begin
				status <= ST_NO_SLOT;
			end else begin
				status <= ST_ALLOC;
				opened_region <= 1'b1;
				block_address <= arena_base + 32'(free_slot_q) * rbytes + HDR_ROUND;
				refs_q[free_slot_q] <= 24'd1;
				woff_q[free_slot_q] <= HDR_ROUND + OW'(need_q);
				stamp_q[free_slot_q] <= open_cnt_q;
			end
		end
	end

	a_hit_live: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && mode_q && hit_q) |-> live_q[hit_slot_q]) else $error("hit on dead slot");
	a_free_dead: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && has_free_q) |-> !live_q[free_slot_q]) else $error("free slot live");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (idx_q <= LAST)) else $error("scan index past last slot");
endmodule

[rtl/refcounted_region_bump_allocator_unit.sv]
// ----------------------------------------------------------------------------
// refcounted_region_bump_allocator_unit
// Region bump allocator with per-region reference counts.
// ----------------------------------------------------------------------------
// Channel   Dir   Word contents
// req       in    mode, request_bytes, free_address
// rsp       out   block_address, status, opened_region
// apb       in    region page count at 0x0, arena_base at 0x4
//
// A word's result is shown after a serial scan over the slot table, slot by slot,
// then a commit step. The unit is ready for the next word in the cycle after the
// result has been accepted, so it takes no new word before the last is through.
// Reset clears all live bits and the open counter at once; no clearing pass.
// A stalled result holds the unit; the request side sees ready low meanwhile.
module refcounted_region_bump_allocator_unit #(
	parameter int MAX_REGIONS  = rrba_pkg::MAX_REGIONS_DEF,
	parameter int PAGE_BYTES   = rrba_pkg::PAGE_BYTES_DEF,
	parameter int ALIGN_UNIT   = rrba_pkg::ALIGN_UNIT_DEF,
	parameter int HEADER_BYTES = rrba_pkg::HEADER_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rrba_in_if.sink                     req,
	rrba_out_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rrba_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import rrba_pkg::*;

	logic [6:0]  pages_q;
	logic [31:0] base_q;
	rrba_cmd_t   cmd;
	rrba_sts_t   sts;

	// Configuration registers; writes land on the access phase.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q <= PAGES_RESET;
			base_q <= BASE_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr == REG_PAGES) pages_q <= pwdata[6:0];
			else if (paddr == REG_BASE) base_q <= pwdata;
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == REG_PAGES) prdata = {25'd0, pages_q};
		else if (paddr == REG_BASE) prdata = base_q;
	end

	rrba_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd, .sts
	);

	rrba_dp #(
		.MAX_REGIONS(MAX_REGIONS), .PAGE_BYTES(PAGE_BYTES),
		.ALIGN_UNIT(ALIGN_UNIT), .HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.region_pages(pages_q), .arena_base(base_q),
		.in_mode(req.mode), .in_request_bytes(req.request_bytes),
		.in_free_address(req.free_address),
		.block_address(rsp.block_address), .status(rsp.status),
		.opened_region(rsp.opened_region)
	);
endmodule
